// ===== hdl/hrlp_pkg.sv =====
// Shared types, codes and method tables for the HTTP request line parser.
package hrlp_pkg;

  // Parse phases of the request line.
  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SLASH,
    PH_PATH,
    PH_QUERY,
    PH_AFTER,
    PH_SKIP
  } phase_t;

  // Byte class tags.
  localparam logic [1:0] CLS_OTHER  = 2'd0;
  localparam logic [1:0] CLS_METHOD = 2'd1;
  localparam logic [1:0] CLS_PATH   = 2'd2;
  localparam logic [1:0] CLS_QUERY  = 2'd3;

  // Final status codes.
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_EMPTY      = 3'd1;
  localparam logic [2:0] ERR_METH_LONG  = 3'd2;
  localparam logic [2:0] ERR_BAD_METHOD = 3'd3;
  localparam logic [2:0] ERR_NO_SLASH   = 3'd4;
  localparam logic [2:0] ERR_BUF_FULL   = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd6;

  // Method codes.
  localparam logic [2:0] METH_GET     = 3'd0;
  localparam logic [2:0] METH_HEAD    = 3'd1;
  localparam logic [2:0] METH_DELETE  = 3'd2;
  localparam logic [2:0] METH_PUT     = 3'd3;
  localparam logic [2:0] METH_POST    = 3'd4;
  localparam logic [2:0] METH_OPTIONS = 3'd5;
  localparam int         NUM_METHODS  = 6;

  // Special bytes.
  localparam logic [7:0]  CH_NUL      = 8'h00;
  localparam logic [7:0]  CH_SP       = 8'h20;
  localparam logic [7:0]  CH_SLASH    = 8'h2F;
  localparam logic [7:0]  CH_QMARK    = 8'h3F;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam logic [23:0] TAIL_CRLFCR = 24'h0D0A0D;

  // Stored method characters: first character in the low byte.
  localparam int METH_CHARS = 8;

  localparam logic [63:0] METHOD_WORDS [NUM_METHODS] = '{
    64'h0000_0000_0054_4547,   // GET
    64'h0000_0000_4441_4548,   // HEAD
    64'h0000_4554_454C_4544,   // DELETE
    64'h0000_0000_0054_5550,   // PUT
    64'h0000_0000_5453_4F50,   // POST
    64'h0053_4E4F_4954_504F    // OPTIONS
  };
  localparam logic [4:0] METHOD_LENS [NUM_METHODS] = '{
    5'd3, 5'd4, 5'd6, 5'd3, 5'd4, 5'd7
  };

  // Configuration register map.
  localparam int         CFG_AW           = 3;
  localparam logic       REG_MAX_PATH_LEN = 1'b0;   // register index, paddr[2]
  localparam logic [9:0] MAX_PATH_RESET   = 10'd512;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } meth_match_t;

  function automatic meth_match_t match_method(input logic [63:0] chars,
                                               input logic [4:0]  count);
    meth_match_t m;
    m.hit  = 1'b0;
    m.code = METH_GET;
    for (int k = NUM_METHODS - 1; k >= 0; k--) begin
      if (count == METHOD_LENS[k] && chars == METHOD_WORDS[k]) begin
        m.hit  = 1'b1;
        m.code = 3'(k);
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/hrlp_in_if.sv =====
// Input channel of the request line parser: one request byte per transaction.
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_request;

  modport source (output valid, output data_byte, output start_request, input ready);
  modport sink   (input valid, input data_byte, input start_request, output ready);
endinterface

// ===== hdl/hrlp_out_if.sv =====
// Result channel of the request line parser: one tagged byte and status per transaction.
interface hrlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] byte_class;
  logic [7:0] out_byte;
  logic       done_res;
  logic [2:0] error_code;
  logic [2:0] method_code;
  logic [9:0] path_length;
  logic       has_query;

  modport source (output valid, output byte_class, output out_byte, output done_res,
                  output error_code, output method_code, output path_length,
                  output has_query, input ready);
  modport sink   (input valid, input byte_class, input out_byte, input done_res,
                  input error_code, input method_code, input path_length,
                  input has_query, output ready);
endinterface

// ===== hdl/http_request_line_parser.sv =====
// Top level of the HTTP request line parser: byte-serial request line and header-end tracking.
//
// The parser takes one request byte per input transaction and returns exactly
// one result transaction per byte, so a byte stream runs through at one byte
// per clock unless the sink stalls. The parse state update and the result are
// formed from the current byte and the state registers, and the result lands
// in a single output register. A new byte is accepted whenever that register
// is empty or is being drained in the same cycle. Each result echoes the byte
// with its class (method, path, query or other) and, on the byte that ends the CR
// LF CR LF header marker, carries the final status, the method code, the path
// length (query included) and the query flag. A header that runs to HEADER_BUF-1
// bytes without a marker ends at once with the overflow code. After the final
// status, bytes are echoed as class "other" until a byte with start_request set
// opens the next request. The max_path_len register sits at APB byte address 0
// and must be written by the user only while the block is idle; the block does not check.
module http_request_line_parser
  import hrlp_pkg::*;
#(
  parameter int METHOD_BUF = 8,
  parameter int PATH_BUF   = 1024,
  parameter int QUERY_BUF  = 512,
  parameter int HEADER_BUF = 8192
) (
  input  logic              clk,
  input  logic              rst_n,
  hrlp_in_if.sink           in_ch,
  hrlp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int MC_W  = $clog2(METHOD_BUF + 1);
  localparam int PC_W  = $clog2(PATH_BUF + 1);
  localparam int QC_W  = $clog2(QUERY_BUF + 1);
  localparam int BC_W  = $clog2(HEADER_BUF);
  localparam int CMP_W = (PC_W > 10) ? PC_W : 10;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [9:0] max_path_len_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_path_len_r <= MAX_PATH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_PATH_LEN) begin
      max_path_len_r <= pwdata[9:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_PATH_LEN) begin
      prdata = {22'd0, max_path_len_r};
    end
  end

  // ---------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------
  phase_t            phase_r, phase_b, phase_nxt;
  logic [23:0]       tail_r, tail_b, tail_nxt;
  logic [BC_W-1:0]   bc_r, bc_b, bc_nxt;
  logic [63:0]       mchars_r, mchars_b, mchars_nxt;
  logic [MC_W-1:0]   mcount_r, mcount_b, mcount_nxt;
  logic [2:0]        mcode_r, mcode_b, mcode_nxt;
  logic [PC_W-1:0]   pcount_r, pcount_b, pcount_nxt;
  logic [QC_W-1:0]   qcount_r, qcount_b, qcount_nxt;
  logic              qseen_r, qseen_b, qseen_nxt;
  logic [2:0]        perr_r, perr_b, perr_nxt;
  logic              fin_r, fin_b, fin_nxt;

  logic              in_fire;
  logic              at_end;
  logic [1:0]        cls_c;
  meth_match_t       mm;
  logic [CMP_W-1:0]  path_ext;
  logic [CMP_W-1:0]  max_ext;

  // Result register
  logic              out_valid_r;
  logic [1:0]        cls_r;
  logic [7:0]        byte_r;
  logic              done_r, done_c;
  logic [2:0]        err_r, err_c;
  logic [2:0]        omcode_r, omcode_c;
  logic [9:0]        plen_r, plen_c;
  logic              hq_r, hq_c;

  logic              in_ready_w;

  // Take a byte whenever the result register is free or drains this cycle.
  assign in_ready_w  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready_w;
  assign in_fire     = in_ch.valid && in_ready_w;

  // Start of request: clear the parse state before this byte is taken.
  always_comb begin
    if (in_ch.start_request) begin
      phase_b  = PH_METHOD;
      tail_b   = '0;
      bc_b     = '0;
      mchars_b = '0;
      mcount_b = '0;
      mcode_b  = METH_GET;
      pcount_b = '0;
      qcount_b = '0;
      qseen_b  = 1'b0;
      perr_b   = ERR_OK;
      fin_b    = 1'b0;
    end else begin
      phase_b  = phase_r;
      tail_b   = tail_r;
      bc_b     = bc_r;
      mchars_b = mchars_r;
      mcount_b = mcount_r;
      mcode_b  = mcode_r;
      pcount_b = pcount_r;
      qcount_b = qcount_r;
      qseen_b  = qseen_r;
      perr_b   = perr_r;
      fin_b    = fin_r;
    end
  end

  // Method held so far, judged on the byte that ends it.
  assign mm = match_method(mchars_b, 5'(mcount_b));

  // Next state: advance the phase and the counters for this byte.
  always_comb begin
    phase_nxt  = phase_b;
    tail_nxt   = tail_b;
    bc_nxt     = bc_b;
    mchars_nxt = mchars_b;
    mcount_nxt = mcount_b;
    mcode_nxt  = mcode_b;
    pcount_nxt = pcount_b;
    qcount_nxt = qcount_b;
    qseen_nxt  = qseen_b;
    perr_nxt   = perr_b;
    cls_c      = CLS_OTHER;
    at_end     = 1'b0;
    if (!fin_b) begin
      bc_nxt   = bc_b + BC_W'(1);
      at_end   = (tail_b == TAIL_CRLFCR) && (in_ch.data_byte == CH_LF);
      tail_nxt = {tail_b[15:0], in_ch.data_byte};
      case (phase_b)
        PH_METHOD: begin
          if (in_ch.data_byte == CH_SP || in_ch.data_byte == CH_NUL) begin
            if (!mm.hit) begin
              perr_nxt  = ERR_BAD_METHOD;
              phase_nxt = PH_SKIP;
            end else begin
              mcode_nxt = mm.code;
              phase_nxt = PH_SLASH;
            end
          end else begin
            if (mcount_b < MC_W'(METH_CHARS)) begin
              mchars_nxt[8*mcount_b[2:0] +: 8] = in_ch.data_byte;
            end
            mcount_nxt = mcount_b + MC_W'(1);
            cls_c      = CLS_METHOD;
            if (mcount_nxt >= MC_W'(METHOD_BUF)) begin
              perr_nxt  = ERR_METH_LONG;
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SLASH: begin
          if (in_ch.data_byte == CH_SLASH) begin
            phase_nxt = PH_PATH;
          end else begin
            perr_nxt  = ERR_NO_SLASH;
            phase_nxt = PH_SKIP;
          end
        end
        PH_PATH: begin
          if (in_ch.data_byte == CH_SP || in_ch.data_byte == CH_NUL) begin
            phase_nxt = PH_AFTER;
          end else begin
            // The '?' itself counts as a path byte, not a query byte.
            if (in_ch.data_byte == CH_QMARK) begin
              qseen_nxt = 1'b1;
              phase_nxt = PH_QUERY;
            end
            pcount_nxt = pcount_b + PC_W'(1);
            cls_c      = CLS_PATH;
            if (pcount_nxt >= PC_W'(PATH_BUF)) begin
              perr_nxt  = ERR_BUF_FULL;
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_QUERY: begin
          if (in_ch.data_byte == CH_SP || in_ch.data_byte == CH_NUL) begin
            phase_nxt = PH_AFTER;
          end else begin
            pcount_nxt = pcount_b + PC_W'(1);
            qcount_nxt = qcount_b + QC_W'(1);
            cls_c      = CLS_QUERY;
            if (pcount_nxt >= PC_W'(PATH_BUF) || qcount_nxt >= QC_W'(QUERY_BUF)) begin
              perr_nxt  = ERR_BUF_FULL;
              phase_nxt = PH_SKIP;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign path_ext = CMP_W'(pcount_nxt);
  assign max_ext  = CMP_W'(max_path_len_r);

  // Outputs: final status on the header marker or on header overflow.
  always_comb begin
    done_c   = 1'b0;
    err_c    = ERR_OK;
    omcode_c = METH_GET;
    plen_c   = '0;
    hq_c     = 1'b0;
    if (!fin_b) begin
      if (at_end) begin
        done_c = 1'b1;
        if (bc_nxt == BC_W'(4)) begin
          err_c = ERR_EMPTY;
        end else if (perr_nxt != ERR_OK) begin
          err_c = perr_nxt;
        end else if (phase_nxt == PH_METHOD) begin
          // The line feed joined the method, so it can never match.
          err_c = ERR_BAD_METHOD;
        end else if (path_ext > max_ext) begin
          err_c = ERR_OVERFLOW;
        end else begin
          omcode_c = mcode_nxt;
          plen_c   = path_ext[9:0];
          hq_c     = qseen_nxt;
        end
      end else if (bc_nxt == BC_W'(HEADER_BUF - 1)) begin
        done_c = 1'b1;
        err_c  = ERR_OVERFLOW;
      end
    end
  end

  assign fin_nxt = fin_b || done_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_METHOD;
      tail_r   <= '0;
      bc_r     <= '0;
      mchars_r <= '0;
      mcount_r <= '0;
      mcode_r  <= METH_GET;
      pcount_r <= '0;
      qcount_r <= '0;
      qseen_r  <= 1'b0;
      perr_r   <= ERR_OK;
      fin_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      tail_r   <= tail_nxt;
      bc_r     <= bc_nxt;
      mchars_r <= mchars_nxt;
      mcount_r <= mcount_nxt;
      mcode_r  <= mcode_nxt;
      pcount_r <= pcount_nxt;
      qcount_r <= qcount_nxt;
      qseen_r  <= qseen_nxt;
      perr_r   <= perr_nxt;
      fin_r    <= fin_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold until the sink takes the transaction.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cls_r    <= cls_c;
      byte_r   <= in_ch.data_byte;
      done_r   <= done_c;
      err_r    <= err_c;
      omcode_r <= omcode_c;
      plen_r   <= plen_c;
      hq_r     <= hq_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_class  = cls_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.error_code  = err_r;
  assign out_ch.method_code = omcode_r;
  assign out_ch.path_length = plen_r;
  assign out_ch.has_query   = hq_r;

endmodule
